// ----- rtl/sm83_dec_pkg.sv -----
`timescale 1ns / 1ps

package sm83_dec_pkg;

  typedef struct packed {
    logic [7:0] opcode;
    logic       halted;
  } dec_in_t;

  typedef struct packed {
    logic [6:0] instr_class;
    logic       locked;
  } dec_out_t;

  // Special class codes
  localparam logic [6:0] CLS_NONE      = 7'd0;
  localparam logic [6:0] CLS_ILLEGAL   = 7'd1;
  localparam logic [6:0] CLS_CB_PREFIX = 7'd2;

  // Base table handlers, column q0
  localparam logic [6:0] CLS_NOP       = 7'd3;
  localparam logic [6:0] CLS_STOP      = 7'd4;
  localparam logic [6:0] CLS_RLCA      = 7'd5;
  localparam logic [6:0] CLS_RRCA      = 7'd6;
  localparam logic [6:0] CLS_RLA       = 7'd7;
  localparam logic [6:0] CLS_RRA       = 7'd8;
  localparam logic [6:0] CLS_DAA       = 7'd9;
  localparam logic [6:0] CLS_CPL       = 7'd10;
  localparam logic [6:0] CLS_SCF       = 7'd11;
  localparam logic [6:0] CLS_CCF       = 7'd12;
  localparam logic [6:0] CLS_JR        = 7'd13;
  localparam logic [6:0] CLS_JR_CC     = 7'd14;
  localparam logic [6:0] CLS_LD_R16_N  = 7'd15;
  localparam logic [6:0] CLS_ST_R16_A  = 7'd16;
  localparam logic [6:0] CLS_LD_A_R16  = 7'd17;
  localparam logic [6:0] CLS_ST_N16_SP = 7'd18;
  localparam logic [6:0] CLS_INC_R16   = 7'd19;
  localparam logic [6:0] CLS_DEC_R16   = 7'd20;
  localparam logic [6:0] CLS_ADD_HL    = 7'd21;
  localparam logic [6:0] CLS_INC_R8    = 7'd22;
  localparam logic [6:0] CLS_DEC_R8    = 7'd23;
  localparam logic [6:0] CLS_LD_R8_N   = 7'd24;

  // Base table handlers, columns q1 and q2
  localparam logic [6:0] CLS_HALT      = 7'd25;
  localparam logic [6:0] CLS_LD_R8_R8  = 7'd26;
  localparam logic [6:0] CLS_ALU_R8    = 7'd27;  // first of eight, add .. cp

  // Base table handlers, column q3
  localparam logic [6:0] CLS_ALU_N8    = 7'd35;  // first of eight, add .. cp
  localparam logic [6:0] CLS_LDH_C_A   = 7'd43;
  localparam logic [6:0] CLS_LDH_N_A   = 7'd44;
  localparam logic [6:0] CLS_ST_N16_A  = 7'd45;
  localparam logic [6:0] CLS_LDH_A_C   = 7'd46;
  localparam logic [6:0] CLS_LDH_A_N   = 7'd47;
  localparam logic [6:0] CLS_LD_A_N16  = 7'd48;
  localparam logic [6:0] CLS_ADD_SP    = 7'd49;
  localparam logic [6:0] CLS_LD_HL_SP  = 7'd50;
  localparam logic [6:0] CLS_CALL      = 7'd51;
  localparam logic [6:0] CLS_LD_SP_HL  = 7'd52;
  localparam logic [6:0] CLS_JP        = 7'd53;
  localparam logic [6:0] CLS_JP_HL     = 7'd54;
  localparam logic [6:0] CLS_RET       = 7'd55;
  localparam logic [6:0] CLS_RETI      = 7'd56;
  localparam logic [6:0] CLS_DI        = 7'd57;
  localparam logic [6:0] CLS_EI        = 7'd58;
  localparam logic [6:0] CLS_RST       = 7'd59;
  localparam logic [6:0] CLS_RET_CC    = 7'd60;
  localparam logic [6:0] CLS_JP_CC     = 7'd61;
  localparam logic [6:0] CLS_CALL_CC   = 7'd62;
  localparam logic [6:0] CLS_POP       = 7'd63;
  localparam logic [6:0] CLS_PUSH      = 7'd64;

  // CB table handlers
  localparam logic [6:0] CLS_CB_SHIFT  = 7'd65;  // first of eight, rlc .. srl
  localparam logic [6:0] CLS_CB_BIT    = 7'd73;  // bit, res, set follow

  localparam logic [7:0] OPC_CB        = 8'hCB;
  localparam logic [7:0] OPC_HALT      = 8'h76;

endpackage

// ----- rtl/sm83_dec_stream_if.sv -----
`timescale 1ns / 1ps

interface sm83_dec_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sm83_opcode_decoder.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Transaction
// in_i      in   opcode[7:0], halted             in_i.valid & in_i.ready
// out_o     out  instr_class[6:0], locked        out_o.valid & out_o.ready
//
// One opcode per cycle unless the result stalls: each accepted transaction is
// decoded in one pass of combinational logic and lands in the result register on the next edge.
// The result register is the only stage.
// Reset clears the CB-prefix and lock flags and empties the result register.
// A stalled result holds; in_i.ready stays high while the result is empty or
// being taken, so a new opcode enters in the same cycle the old one leaves.

module sm83_opcode_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sm83_dec_stream_if.sink           in_i,
  sm83_dec_stream_if.source         out_o
);
  import sm83_dec_pkg::*;

  logic     cb_pending_q, cb_pending_d;
  logic     lock_flag_q, lock_flag_d;
  logic     out_valid_q;
  dec_out_t res_q, res_d;
  logic     in_fire;
  logic     illegal;

  // Column q0: misc, 16-bit loads and increments, 8-bit inc/dec/load
  function automatic logic [6:0] dec_q0(input logic [7:0] b);
    logic [6:0] cls;
    cls = CLS_NONE;
    case (b)
      8'h00: cls = CLS_NOP;
      8'h10: cls = CLS_STOP;
      8'h07: cls = CLS_RLCA;
      8'h0F: cls = CLS_RRCA;
      8'h17: cls = CLS_RLA;
      8'h1F: cls = CLS_RRA;
      8'h27: cls = CLS_DAA;
      8'h2F: cls = CLS_CPL;
      8'h37: cls = CLS_SCF;
      8'h3F: cls = CLS_CCF;
      8'h18: cls = CLS_JR;
      default: begin
        if ((b & 8'hE7) == 8'h20) begin
          cls = CLS_JR_CC;
        end else begin
          case (b[3:0])
            4'h1: cls = CLS_LD_R16_N;
            4'h2: cls = CLS_ST_R16_A;
            4'hA: cls = CLS_LD_A_R16;
            4'h8: cls = CLS_ST_N16_SP;
            4'h3: cls = CLS_INC_R16;
            4'hB: cls = CLS_DEC_R16;
            4'h9: cls = CLS_ADD_HL;
            default: begin
              case (b[2:0])
                3'd4: cls = CLS_INC_R8;
                3'd5: cls = CLS_DEC_R8;
                3'd6: cls = CLS_LD_R8_N;
                default: cls = CLS_NONE;
              endcase
            end
          endcase
        end
      end
    endcase
    return cls;
  endfunction

  // Column q3: immediate ALU, high-page loads, control flow, stack
  function automatic logic [6:0] dec_q3(input logic [7:0] b);
    logic [6:0] cls;
    cls = CLS_NONE;
    case (b)
      8'hC6, 8'hCE, 8'hD6, 8'hDE, 8'hE6, 8'hEE, 8'hF6, 8'hFE:
        cls = CLS_ALU_N8 + {4'd0, b[5:3]};
      8'hE2: cls = CLS_LDH_C_A;
      8'hE0: cls = CLS_LDH_N_A;
      8'hEA: cls = CLS_ST_N16_A;
      8'hF2: cls = CLS_LDH_A_C;
      8'hF0: cls = CLS_LDH_A_N;
      8'hFA: cls = CLS_LD_A_N16;
      8'hE8: cls = CLS_ADD_SP;
      8'hF8: cls = CLS_LD_HL_SP;
      8'hCD: cls = CLS_CALL;
      8'hF9: cls = CLS_LD_SP_HL;
      8'hC3: cls = CLS_JP;
      8'hE9: cls = CLS_JP_HL;
      8'hC9: cls = CLS_RET;
      8'hD9: cls = CLS_RETI;
      8'hF3: cls = CLS_DI;
      8'hFB: cls = CLS_EI;
      default: begin
        if (b[2:0] == 3'd7) begin
          cls = CLS_RST;
        end else if (!b[5] && b[2:0] == 3'd0) begin
          cls = CLS_RET_CC;
        end else if (!b[5] && b[2:0] == 3'd2) begin
          cls = CLS_JP_CC;
        end else if (!b[5] && b[2:0] == 3'd4) begin
          cls = CLS_CALL_CC;
        end else if (b[3:0] == 4'h1) begin
          cls = CLS_POP;
        end else if (b[3:0] == 4'h5) begin
          cls = CLS_PUSH;
        end else begin
          cls = CLS_NONE;
        end
      end
    endcase
    return cls;
  endfunction

  function automatic logic [6:0] dec_cb(input logic [7:0] b);
    logic [6:0] cls;
    if (b[7:6] == 2'd0) begin
      cls = CLS_CB_SHIFT + {4'd0, b[5:3]};
    end else begin
      cls = CLS_CB_BIT + {5'd0, b[7:6]} - 7'd1;
    end
    return cls;
  endfunction

  function automatic logic [6:0] dec_base(input logic [7:0] b);
    logic [6:0] cls;
    case (b[7:6])
      2'd0: cls = dec_q0(b);
      2'd1: cls = (b == OPC_HALT) ? CLS_HALT : CLS_LD_R8_R8;
      2'd2: cls = CLS_ALU_R8 + {4'd0, b[5:3]};
      default: cls = dec_q3(b);
    endcase
    return cls;
  endfunction

  // Take a new opcode whenever the result register is empty or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // The eleven unused base opcodes
  assign illegal = in_i.data.opcode inside {8'hD3, 8'hDB, 8'hDD, 8'hE3, 8'hE4, 8'hEB,
                                            8'hEC, 8'hED, 8'hF4, 8'hFC, 8'hFD};

  // Decode priority: halt, pending prefix, illegal, prefix byte, base table.
  always_comb begin
    cb_pending_d      = cb_pending_q;
    lock_flag_d       = lock_flag_q;
    res_d.instr_class = CLS_NONE;
    if (!in_i.data.halted) begin
      if (cb_pending_q) begin
        // After a prefix every byte, 0xCB and the unused ones too, is a CB opcode.
        res_d.instr_class = dec_cb(in_i.data.opcode);
        cb_pending_d      = 1'b0;
      end else if (illegal) begin
        res_d.instr_class = CLS_ILLEGAL;
        lock_flag_d       = 1'b1;
      end else if (in_i.data.opcode == OPC_CB) begin
        res_d.instr_class = CLS_CB_PREFIX;
        cb_pending_d      = 1'b1;
      end else begin
        res_d.instr_class = dec_base(in_i.data.opcode);
      end
    end
    res_d.locked = lock_flag_d;
  end

  // Advance decode state only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_pending_q <= 1'b0;
      lock_flag_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        cb_pending_q <= cb_pending_d;
        lock_flag_q  <= lock_flag_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

`ifndef ASSERT_OFF
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_flag_q |=> lock_flag_q)
    else $error("lock flag cleared");

  a_halt_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.data.halted) |=> ($stable(cb_pending_q) && $stable(lock_flag_q)))
    else $error("halted transaction changed decode state");

  a_prefix_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.instr_class == CLS_CB_PREFIX) |=> cb_pending_q)
    else $error("CB prefix did not arm pending flag");

  a_illegal_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.instr_class == CLS_ILLEGAL) |-> res_q.locked)
    else $error("illegal class without lock");
`endif

endmodule
